// ===== rtl/core/bfc_pkg.sv =====
// ============================================================================
// bfc_pkg
// Shared types, character codes, status codes and decode helpers for the
// bracket formula checker.
// ============================================================================
package bfc_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 64;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef logic [LVL_W-1:0]  level_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [1:0]        kind_t;
    typedef logic [3:0]        status_t;
    typedef logic [1:0]        eq_cnt_t;
    typedef logic [1:0]        ill_t;
    typedef logic [7:0]        char_t;

    // Bracket kinds
    localparam kind_t KIND_ROUND  = 2'd0;
    localparam kind_t KIND_CURLY  = 2'd1;
    localparam kind_t KIND_SQUARE = 2'd2;
    localparam kind_t KIND_ANGLE  = 2'd3;

    // Illegal character record
    localparam ill_t ILL_NONE = 2'd0;
    localparam ill_t ILL_AMP  = 2'd1;
    localparam ill_t ILL_HASH = 2'd2;

    // Status codes
    localparam status_t ST_OK        = 4'd0;
    localparam status_t ST_MANY_EQ   = 4'd1;
    localparam status_t ST_UNCLOSED  = 4'd2;
    localparam status_t ST_UNOPENED  = 4'd3;
    localparam status_t ST_NESTED_EQ = 4'd4;
    localparam status_t ST_MIXED     = 4'd5;
    localparam status_t ST_AMP       = 4'd6;
    localparam status_t ST_HASH      = 4'd7;
    localparam status_t ST_OVERFLOW  = 4'd8;

    // ASCII codes
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_LCURLY = 8'h7B;
    localparam char_t CH_RCURLY = 8'h7D;
    localparam char_t CH_LSQ    = 8'h5B;
    localparam char_t CH_RSQ    = 8'h5D;
    localparam char_t CH_LANGLE = 8'h3C;
    localparam char_t CH_RANGLE = 8'h3E;
    localparam char_t CH_EQUAL  = 8'h3D;
    localparam char_t CH_AMP    = 8'h26;
    localparam char_t CH_HASH   = 8'h23;

    function automatic logic is_opener(input char_t c);
        return c inside {CH_LPAREN, CH_LCURLY, CH_LSQ, CH_LANGLE};
    endfunction

    function automatic logic is_closer(input char_t c);
        return c inside {CH_RPAREN, CH_RCURLY, CH_RSQ, CH_RANGLE};
    endfunction

    // Kind of an opener or closer; other characters map to round (unused)
    function automatic kind_t bracket_kind(input char_t c);
        kind_t k;
        case (c)
            CH_LCURLY, CH_RCURLY: k = KIND_CURLY;
            CH_LSQ, CH_RSQ:       k = KIND_SQUARE;
            CH_LANGLE, CH_RANGLE: k = KIND_ANGLE;
            default:              k = KIND_ROUND;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/bfc_ram.sv =====
// ============================================================================
// bfc_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. Contents are not reset.
// ============================================================================
module bfc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/bracket_formula_checker.sv =====
// ============================================================================
// bracket_formula_checker
// Streaming bracket and formula syntax checker with one status per formula.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one ASCII character per transfer,
//   final_char marks the last character of a formula. Output channel
//   (out_valid/out_ready): one 4-bit status per formula, nothing for the
//   other characters.
//   Throughput: one character per cycle while in_ready is high. The stack
//   lives in a single RAM; the top entry is kept in a register and the
//   entry below it is prefetched every cycle from the RAM read port (with a
//   bypass for the entry written in the same cycle), so each push or pop
//   takes one RAM access.
//   Output: the status is registered into the output register, or into the
//   skid entry while an earlier status still waits in the output register.
//   Reset: control state, counters and flags clear at once; the stack RAM
//   is not cleared, as only pushed entries are ever popped. The block
//   accepts characters from the first cycle after reset.
//   Stall: results go to a two-entry output buffer. in_ready stays high
//   while the second entry is free, so characters keep flowing while one
//   status waits; it drops only when two statuses are waiting.
// ============================================================================
module bracket_formula_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           character,
    input  logic                 final_char,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           status
);

    // Scan state
    bfc_pkg::level_t  level_reg,  level_next;
    bfc_pkg::kind_t   top_reg,    top_next;
    bfc_pkg::eq_cnt_t eq_reg,     eq_next;
    bfc_pkg::status_t err_reg,    err_next;
    logic             nested_reg, nested_next;
    bfc_pkg::ill_t    ill_reg,    ill_next;

    // Stack RAM access
    logic             wr_en;
    bfc_pkg::addr_t   wr_addr;
    bfc_pkg::addr_t   rd_addr;
    bfc_pkg::kind_t   rd_data;
    bfc_pkg::kind_t   second;
    logic             byp_reg;
    bfc_pkg::kind_t   byp_data_reg;
    bfc_pkg::level_t  level_m1;
    bfc_pkg::level_t  level_next_m2;

    // Output buffer
    logic             out_valid_reg, out_valid_next;
    bfc_pkg::status_t out_data_reg,  out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    bfc_pkg::status_t skid_data_reg,  skid_data_next;

    logic             accept;
    logic             push_res;
    logic             pop_res;
    bfc_pkg::status_t final_st;
    bfc_pkg::kind_t   ch_kind;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = out_data_reg;

    // Entry below the top: RAM read, or the value written last cycle
    assign second = byp_reg ? byp_data_reg : rd_data;

    assign ch_kind       = bfc_pkg::bracket_kind(character);
    assign level_m1      = level_reg - bfc_pkg::LVL_W'(1);
    assign level_next_m2 = level_next - bfc_pkg::LVL_W'(2);
    assign wr_addr       = level_m1[bfc_pkg::ADDR_W-1:0];
    assign rd_addr       = level_next_m2[bfc_pkg::ADDR_W-1:0];

    // Character scan and final status
    always_comb
    begin
        level_next  = level_reg;
        top_next    = top_reg;
        eq_next     = eq_reg;
        err_next    = err_reg;
        nested_next = nested_reg;
        ill_next    = ill_reg;
        wr_en       = 1'b0;
        final_st    = bfc_pkg::ST_OK;

        if (accept)
        begin
            if (character == bfc_pkg::CH_EQUAL && eq_reg < 2'd2)
            begin
                eq_next = eq_reg + 2'd1;
            end

            if (err_reg == bfc_pkg::ST_OK)
            begin
                if (bfc_pkg::is_opener(character))
                begin
                    if (level_reg == bfc_pkg::LVL_W'(bfc_pkg::STACK_DEPTH))
                    begin
                        err_next = bfc_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // old top spills to RAM below the new top
                        wr_en      = (level_reg != '0);
                        top_next   = ch_kind;
                        level_next = level_reg + bfc_pkg::LVL_W'(1);
                    end
                end
                else if (bfc_pkg::is_closer(character))
                begin
                    if (level_reg == '0)
                    begin
                        err_next = bfc_pkg::ST_UNOPENED;
                    end
                    else
                    begin
                        level_next = level_m1;
                        top_next   = second;
                        if (top_reg != ch_kind)
                        begin
                            err_next = bfc_pkg::ST_MIXED;
                        end
                    end
                end
                else if (character == bfc_pkg::CH_EQUAL)
                begin
                    if (level_reg != '0)
                    begin
                        nested_next = 1'b1;
                    end
                end
                else if (character == bfc_pkg::CH_AMP)
                begin
                    ill_next = bfc_pkg::ILL_AMP;
                end
                else if (character == bfc_pkg::CH_HASH)
                begin
                    ill_next = bfc_pkg::ILL_HASH;
                end
            end

            // Ranked status over the state after this character
            if (eq_next > 2'd1)
                final_st = bfc_pkg::ST_MANY_EQ;
            else if (err_next != bfc_pkg::ST_OK)
                final_st = err_next;
            else if (level_next != '0)
                final_st = bfc_pkg::ST_UNCLOSED;
            else if (nested_next)
                final_st = bfc_pkg::ST_NESTED_EQ;
            else if (ill_next == bfc_pkg::ILL_AMP)
                final_st = bfc_pkg::ST_AMP;
            else if (ill_next == bfc_pkg::ILL_HASH)
                final_st = bfc_pkg::ST_HASH;
            else
                final_st = bfc_pkg::ST_OK;

            // Formula done: clear for the next one
            if (final_char)
            begin
                level_next  = '0;
                eq_next     = '0;
                err_next    = bfc_pkg::ST_OK;
                nested_next = 1'b0;
                ill_next    = bfc_pkg::ILL_NONE;
            end
        end
    end

    // Output buffer: main register plus one skid entry
    assign push_res = accept && final_char;
    assign pop_res  = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (pop_res)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (push_res)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = final_st;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = final_st;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            eq_reg         <= '0;
            err_reg        <= bfc_pkg::ST_OK;
            nested_reg     <= 1'b0;
            ill_reg        <= bfc_pkg::ILL_NONE;
            byp_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            eq_reg         <= eq_next;
            err_reg        <= err_next;
            nested_reg     <= nested_next;
            ill_reg        <= ill_next;
            byp_reg        <= wr_en;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        byp_data_reg  <= top_reg;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Stack storage (entries below the cached top)
    bfc_ram #(
        .WIDTH (2),
        .DEPTH (bfc_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Assertions
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a status while the output register is empty");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_char) |=> (level_reg == '0 && eq_reg == '0
                                    && err_reg == bfc_pkg::ST_OK))
        else $error("scan state not cleared after the last character");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= bfc_pkg::LVL_W'(bfc_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    a_frozen_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != bfc_pkg::ST_OK && !(accept && final_char)) |=> $stable(level_reg))
        else $error("stack moved after a scan error");

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_char) |=> out_valid_reg)
        else $error("no status after the last character");

endmodule
